// File: rtl/core/i2c_mps_pkg.sv
package i2c_mps_pkg;

    // command codes, equal to the action field of a request
    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_INIT    = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_READ    = 3'd5,
        OP_RECOVER = 3'd6,
        OP_RELEASE = 3'd7
    } t_op;

    localparam int STEP_W = 5;

    // step numbers that bound or mark the phases of the write, read and recover sequences
    localparam logic [STEP_W-1:0] WR_BITS_END  = 5'd24;
    localparam logic [STEP_W-1:0] WR_SCL_LOW   = 5'd24;
    localparam logic [STEP_W-1:0] WR_SDA_REL   = 5'd25;
    localparam logic [STEP_W-1:0] WR_SCL_HIGH  = 5'd26;
    localparam logic [STEP_W-1:0] WR_ACK_SAMP  = 5'd27;
    localparam logic [STEP_W-1:0] RD_BITS_LAST = 5'd16;
    localparam logic [STEP_W-1:0] RD_ACK_DRV   = 5'd17;
    localparam logic [STEP_W-1:0] RD_ACK_HIGH  = 5'd18;
    localparam logic [STEP_W-1:0] RC_CLK_LAST  = 5'd18;

    localparam logic [7:0] FIRST_BIT = 8'h80;

    // pin state: drive enable and level of each line
    typedef struct packed {
        logic scl_drive;
        logic scl_level;
        logic sda_drive;
        logic sda_level;
    } t_pins;

    // classified request handed from front to back
    typedef struct packed {
        t_op        op;
        logic       is_cmd;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_sample;
    } t_cmd;

    // one result item
    typedef struct packed {
        t_pins      pins;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } t_res;

endpackage

// File: rtl/core/i2c_mps_front.sv
module i2c_mps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_action,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_ack_to_send,
    input  logic                i_sda_sample,
    output logic                o_cmd_valid,
    output i2c_mps_pkg::t_cmd   o_cmd,
    input  logic                i_cmd_take
);
    import i2c_mps_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_put;
    t_cmd       w_cmd;

    // classify the request
    always_comb begin
        w_cmd.op          = t_op'(i_action);
        w_cmd.is_cmd      = (t_op'(i_action) != OP_IDLE);
        w_cmd.tx_byte     = i_tx_byte;
        w_cmd.ack_to_send = i_ack_to_send;
        w_cmd.sda_sample  = i_sda_sample;
    end

    assign full        = (r_count == 2'd2);
    assign w_put       = push && !full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_put;
        n_rd_ptr = r_rd_ptr ^ i_cmd_take;
        n_count  = r_count + {1'b0, w_put} - {1'b0, i_cmd_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: rtl/core/i2c_mps_back.sv
module i2c_mps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  i2c_mps_pkg::t_cmd   i_cmd,
    output logic                o_cmd_take,
    input  logic                i_res_full,
    output logic                o_res_push,
    output i2c_mps_pkg::t_res   o_res
);
    import i2c_mps_pkg::*;

    t_op               r_op, n_op;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_phase, n_phase;
    logic [7:0]        r_mask, n_mask;
    logic [7:0]        r_shift_out, n_shift_out;
    logic [7:0]        r_shift_in, n_shift_in;
    logic              r_ack_lvl, n_ack_lvl;
    logic              r_ack_latch, n_ack_latch;
    t_pins             r_pins, n_pins;
    logic              w_fire;
    logic              w_done;
    logic              w_rej;

    assign w_fire     = i_cmd_valid && !i_res_full;
    assign o_cmd_take = w_fire;
    assign o_res_push = w_fire;

    // accept or reject a command, then perform the next pin step of the running sequence
    always_comb begin
        n_op        = r_op;
        n_step      = r_step;
        n_phase     = r_phase;
        n_mask      = r_mask;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_ack_lvl   = r_ack_lvl;
        n_ack_latch = r_ack_latch;
        n_pins      = r_pins;
        w_done      = 1'b0;
        w_rej       = 1'b0;

        if (r_op == OP_IDLE) begin
            if (i_cmd.is_cmd) begin
                n_op      = i_cmd.op;
                n_step    = '0;
                n_phase   = 2'd0;
                n_mask    = FIRST_BIT;
                n_ack_lvl = 1'b0;
                if (i_cmd.op == OP_WRITE) begin
                    n_shift_out = i_cmd.tx_byte;
                end
                if (i_cmd.op == OP_READ) begin
                    n_shift_out = 8'h00;
                    n_ack_lvl   = i_cmd.ack_to_send;
                end
            end
        end else if (i_cmd.is_cmd) begin
            w_rej = 1'b1;
        end

        unique case (n_op)
            OP_IDLE: begin
            end
            OP_INIT: begin
                n_pins = '{1'b1, 1'b1, 1'b1, 1'b1};
                w_done = 1'b1;
            end
            OP_START: begin
                unique case (n_step)
                    5'd0:    begin n_pins.sda_drive = 1'b1; n_pins.sda_level = 1'b1; end
                    5'd1:    begin n_pins.scl_drive = 1'b1; n_pins.scl_level = 1'b1; end
                    default: begin
                        n_pins.sda_drive = 1'b1;
                        n_pins.sda_level = 1'b0;
                        w_done = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                unique case (n_step)
                    5'd0:    begin n_pins.sda_drive = 1'b1; n_pins.sda_level = 1'b0; end
                    5'd1:    begin n_pins.scl_drive = 1'b1; n_pins.scl_level = 1'b1; end
                    default: begin
                        n_pins.sda_drive = 1'b1;
                        n_pins.sda_level = 1'b1;
                        w_done = 1'b1;
                    end
                endcase
            end
            OP_WRITE: begin
                if (n_step < WR_BITS_END) begin
                    // three steps per data bit, tracked by the phase counter
                    unique case (n_phase)
                        2'd0: begin
                            n_pins.scl_drive = 1'b1;
                            n_pins.scl_level = 1'b0;
                        end
                        2'd1: begin
                            n_pins.sda_drive = 1'b1;
                            n_pins.sda_level = |(n_shift_out & n_mask);
                        end
                        default: begin
                            n_pins.scl_drive = 1'b1;
                            n_pins.scl_level = 1'b1;
                            n_mask = n_mask >> 1;
                        end
                    endcase
                    n_phase = (n_phase == 2'd2) ? 2'd0 : n_phase + 2'd1;
                end else if (n_step == WR_SCL_LOW) begin
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = 1'b0;
                end else if (n_step == WR_SDA_REL) begin
                    n_pins.sda_drive = 1'b0;
                end else if (n_step == WR_SCL_HIGH) begin
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = 1'b1;
                end else if (n_step == WR_ACK_SAMP) begin
                    n_ack_latch      = i_cmd.sda_sample;
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = 1'b0;
                end else begin
                    n_pins.sda_drive = 1'b1;
                    w_done = 1'b1;
                end
            end
            OP_READ: begin
                if (n_step == '0) begin
                    n_pins.sda_drive = 1'b0;
                end else if (n_step <= RD_BITS_LAST) begin
                    if (n_step[0]) begin
                        n_pins.scl_drive = 1'b1;
                        n_pins.scl_level = 1'b1;
                    end else begin
                        if (i_cmd.sda_sample) begin
                            n_shift_out = n_shift_out | n_mask;
                        end
                        n_mask = n_mask >> 1;
                        n_pins.scl_drive = 1'b1;
                        n_pins.scl_level = 1'b0;
                        if (n_step == RD_BITS_LAST) begin
                            n_shift_in = n_shift_out;
                        end
                    end
                end else if (n_step == RD_ACK_DRV) begin
                    n_pins.sda_drive = 1'b1;
                    n_pins.sda_level = n_ack_lvl;
                end else if (n_step == RD_ACK_HIGH) begin
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = 1'b1;
                end else begin
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = 1'b0;
                    w_done = 1'b1;
                end
            end
            OP_RECOVER: begin
                if (n_step == '0) begin
                    n_pins.sda_drive = 1'b0;
                    n_pins.sda_level = 1'b0;
                end else if (n_step <= RC_CLK_LAST) begin
                    n_pins.scl_drive = 1'b1;
                    n_pins.scl_level = !n_step[0];
                end else begin
                    n_pins = '{1'b1, 1'b1, 1'b1, 1'b1};
                    w_done = 1'b1;
                end
            end
            OP_RELEASE: begin
                n_pins = '{1'b0, 1'b0, 1'b0, 1'b0};
                w_done = 1'b1;
            end
            default: begin
            end
        endcase

        // advance or finish the sequence
        if (n_op != OP_IDLE) begin
            if (w_done) begin
                n_op   = OP_IDLE;
                n_step = '0;
            end else begin
                n_step = n_step + 1'b1;
            end
        end
    end

    // result of this step
    always_comb begin
        o_res.pins     = n_pins;
        o_res.busy_res = (n_op != OP_IDLE);
        o_res.done_res = w_done;
        o_res.rx_byte  = n_shift_in;
        o_res.ack_seen = n_ack_latch;
        o_res.rejected = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_IDLE;
            r_step      <= '0;
            r_phase     <= 2'd0;
            r_mask      <= 8'h00;
            r_shift_out <= 8'h00;
            r_shift_in  <= 8'h00;
            r_ack_lvl   <= 1'b0;
            r_ack_latch <= 1'b1;
            r_pins      <= '{1'b0, 1'b1, 1'b0, 1'b1};
        end else if (w_fire) begin
            r_op        <= n_op;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_mask      <= n_mask;
            r_shift_out <= n_shift_out;
            r_shift_in  <= n_shift_in;
            r_ack_lvl   <= n_ack_lvl;
            r_ack_latch <= n_ack_latch;
            r_pins      <= n_pins;
        end
    end

endmodule

// File: rtl/core/i2c_mps_resq.sv
module i2c_mps_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_push,
    input  i2c_mps_pkg::t_res   i_res,
    output logic                o_res_full,
    output logic                empty,
    input  logic                pop,
    output i2c_mps_pkg::t_res   o_res
);
    import i2c_mps_pkg::*;

    t_res       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_take;

    assign o_res_full = (r_count == 2'd2);
    assign empty      = (r_count == 2'd0);
    assign w_take     = pop && !empty;
    assign o_res      = r_mem[r_rd_ptr];

    // pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_res_push;
        n_rd_ptr = r_rd_ptr ^ w_take;
        n_count  = r_count + {1'b0, i_res_push} - {1'b0, w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

// File: rtl/core/i2c_master_pin_sequencer_core.sv
// I2C master pin sequencer: each request is one tick of the bus and yields
// one result with the SCL/SDA drive and level after that tick's pin step.
// A nonzero action starts a command (init, start, stop, write, read, recover,
// release) when idle; a command arriving while busy is reported as rejected
// and the running sequence still advances. One request per clock is sustained
// while the result queue has room; a request is held in the two-entry input
// queue, then the sequencer step writes its result into the two-entry result
// queue. Without a stall the sequencer performs one pin step per cycle.
module i2c_master_pin_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_action,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_to_send,
    input  logic       i_sda_sample,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_drive,
    output logic       o_scl_level,
    output logic       o_sda_drive,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_seen,
    output logic       o_rejected
);
    import i2c_mps_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;
    logic w_res_full;
    logic w_res_push;
    t_res w_res;
    t_res w_out;

    // request queue and classification
    i2c_mps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_tx_byte     (i_tx_byte),
        .i_ack_to_send (i_ack_to_send),
        .i_sda_sample  (i_sda_sample),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_take    (w_cmd_take)
    );

    // pin step sequencer
    i2c_mps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue
    i2c_mps_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (w_res_push),
        .i_res      (w_res),
        .o_res_full (w_res_full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (w_out)
    );

    assign o_scl_drive = w_out.pins.scl_drive;
    assign o_scl_level = w_out.pins.scl_level;
    assign o_sda_drive = w_out.pins.sda_drive;
    assign o_sda_level = w_out.pins.sda_level;
    assign o_busy_res  = w_out.busy_res;
    assign o_done_res  = w_out.done_res;
    assign o_rx_byte   = w_out.rx_byte;
    assign o_ack_seen  = w_out.ack_seen;
    assign o_rejected  = w_out.rejected;

endmodule
